### rtl/core/dedup_packet_fifo_with_window_count_core_assert.svh
// assertion macros used by the packet fifo sequencer rtl
`ifndef DEDUP_PACKET_FIFO_WITH_WINDOW_COUNT_CORE_ASSERT_SVH
`define DEDUP_PACKET_FIFO_WITH_WINDOW_COUNT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dpfifo_pkg.sv
// shared types, constants and helpers of the packet fifo
`timescale 1ns / 1ps
package dpfifo_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int OCC_W     = $clog2(MAX_DEPTH + 1);
  localparam int LIMIT_W   = 7;
  localparam int CMP_W     = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam int CNT_W     = 7;
  localparam int ENTRY_W   = 64;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  localparam logic [1:0] MODE_RECV  = 2'd0;
  localparam logic [1:0] MODE_DISP  = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
    logic [31:0] wlo;
    logic [31:0] whi;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             has_packet;
    logic [15:0]      src;
    logic [15:0]      dst;
    logic [31:0]      ts;
    logic [CNT_W-1:0] window_count;
  } res_t;

  typedef struct packed {
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = p + PTR_W'(1);
    if (p == PTR_W'(MAX_DEPTH - 1)) n = '0;
    return n;
  endfunction

endpackage

### rtl/core/dpfifo_ram.sv
// simple dual-port ram with registered read data
`timescale 1ns / 1ps
module dpfifo_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/dpfifo_seq.sv
// request sequencer: ring pointers, entry scan and result register
`timescale 1ns / 1ps
`include "dedup_packet_fifo_with_window_count_core_assert.svh"
module dpfifo_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen_i,
  input  logic [dpfifo_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dpfifo_pkg::req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dpfifo_pkg::res_t                out_res_o,
  output dpfifo_pkg::mem_req_t            mem_req_o,
  input  logic [dpfifo_pkg::ENTRY_W-1:0]  rd_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                             state_r, state_nxt;
  logic [dpfifo_pkg::LIMIT_W-1:0]     limit_r, limit_nxt;
  logic [dpfifo_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [dpfifo_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic [dpfifo_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic [dpfifo_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dpfifo_pkg::OCC_W-1:0]       left_r, left_nxt;
  logic                               rd_vld_r, rd_vld_nxt;
  logic                               out_vld_r, out_vld_nxt;
  logic                               dup_r, dup_nxt;
  logic [dpfifo_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  dpfifo_pkg::req_t                   req_r, req_nxt;
  dpfifo_pkg::entry_t                 pop_r, pop_nxt;
  dpfifo_pkg::res_t                   res_r, res_nxt;

  dpfifo_pkg::entry_t                 ent;
  dpfifo_pkg::mem_req_t               mem_req;
  logic                               key_hit;
  logic                               win_hit;
  logic                               evict;
  logic [dpfifo_pkg::CMP_W-1:0]       lim_ext;
  logic [dpfifo_pkg::CMP_W-1:0]       eff_lim;

  assign ent     = dpfifo_pkg::entry_t'(rd_data_i);
  assign key_hit = (ent.src == req_r.src) && (ent.dst == req_r.dst) && (ent.ts == req_r.ts);
  assign win_hit = (ent.dst == req_r.dst) && (ent.ts >= req_r.wlo) && (ent.ts <= req_r.whi);

  // limit saturated to 1..depth
  always_comb begin
    lim_ext = dpfifo_pkg::CMP_W'(limit_r);
    eff_lim = lim_ext;
    if (lim_ext == '0) eff_lim = dpfifo_pkg::CMP_W'(1);
    if (lim_ext > dpfifo_pkg::CMP_W'(dpfifo_pkg::MAX_DEPTH)) begin
      eff_lim = dpfifo_pkg::CMP_W'(dpfifo_pkg::MAX_DEPTH);
    end
  end

  assign evict = (dpfifo_pkg::CMP_W'(occ_r) >= eff_lim) && (occ_r != '0);

  always_comb begin
    state_nxt   = state_r;
    limit_nxt   = limit_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    rd_ptr_nxt  = rd_ptr_r;
    left_nxt    = left_r;
    rd_vld_nxt  = 1'b0;
    out_vld_nxt = out_vld_r;
    dup_nxt     = dup_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    pop_nxt     = pop_r;
    res_nxt     = res_r;
    mem_req     = '0;

    if (cfg_wen_i) limit_nxt = cfg_wdata_i;
    if (out_vld_r && out_ready_i) out_vld_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_nxt    = in_req_i;
          dup_nxt    = 1'b0;
          cnt_nxt    = '0;
          rd_ptr_nxt = head_r;
          left_nxt   = (in_req_i.mode == dpfifo_pkg::MODE_DISP) ?
                       dpfifo_pkg::OCC_W'(1) : occ_r;
          if (occ_r != '0 && in_req_i.mode != dpfifo_pkg::MODE_NOP) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (left_r != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_ptr_r;
          rd_ptr_nxt      = dpfifo_pkg::next_ptr(rd_ptr_r);
          left_nxt        = left_r - dpfifo_pkg::OCC_W'(1);
          rd_vld_nxt      = 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
        if (rd_vld_r) begin
          pop_nxt = ent;
          if (key_hit) dup_nxt = 1'b1;
          if (win_hit && cnt_r != dpfifo_pkg::CNT_MAX) begin
            cnt_nxt = cnt_r + dpfifo_pkg::CNT_W'(1);
          end
        end
      end
      ST_FINISH: begin
        if (!out_vld_r || out_ready_i) begin
          out_vld_nxt = 1'b1;
          res_nxt     = '0;
          state_nxt   = ST_IDLE;
          case (req_r.mode)
            dpfifo_pkg::MODE_RECV: begin
              if (!dup_r) begin
                res_nxt.accepted = 1'b1;
                mem_req.wr_en    = 1'b1;
                mem_req.wr_addr  = tail_r;
                mem_req.wr_data  = {req_r.src, req_r.dst, req_r.ts};
                tail_nxt         = dpfifo_pkg::next_ptr(tail_r);
                if (evict) begin
                  head_nxt = dpfifo_pkg::next_ptr(head_r);
                end else begin
                  occ_nxt = occ_r + dpfifo_pkg::OCC_W'(1);
                end
              end
            end
            dpfifo_pkg::MODE_DISP: begin
              if (occ_r != '0) begin
                res_nxt.has_packet = 1'b1;
                res_nxt.src        = pop_r.src;
                res_nxt.dst        = pop_r.dst;
                res_nxt.ts         = pop_r.ts;
                head_nxt           = dpfifo_pkg::next_ptr(head_r);
                occ_nxt            = occ_r - dpfifo_pkg::OCC_W'(1);
              end
            end
            dpfifo_pkg::MODE_COUNT: begin
              res_nxt.window_count = cnt_r;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      limit_r   <= dpfifo_pkg::LIMIT_RESET;
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      left_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      limit_r   <= limit_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      occ_r     <= occ_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      left_r    <= left_nxt;
    end
    rd_ptr_r <= rd_ptr_nxt;
    dup_r    <= dup_nxt;
    cnt_r    <= cnt_nxt;
    req_r    <= req_nxt;
    pop_r    <= pop_nxt;
    res_r    <= res_nxt;
  end

  assign in_ready_o  = (state_r == ST_IDLE);
  assign out_valid_o = out_vld_r;
  assign out_res_o   = res_r;
  assign mem_req_o   = mem_req;

  `DPF_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= dpfifo_pkg::OCC_W'(dpfifo_pkg::MAX_DEPTH), "occupancy above depth")
  `DPF_ASSERT_NOW(a_scan_nonempty, clk, rst_n, state_r == ST_SCAN, occ_r != '0, "scan with empty fifo")
  `DPF_ASSERT_NOW(a_wr_no_rd, clk, rst_n, mem_req.wr_en, !mem_req.rd_en, "read during entry write")
  `DPF_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid_i && in_ready_o, !in_ready_o, "ready right after request")

endmodule

### rtl/core/dedup_packet_fifo_with_window_count_core.sv
// top level of the packet fifo with duplicate filter and window count
`timescale 1ns / 1ps
// Bounded packet fifo of up to 64 entries held in one synchronous ram.
// Each request is taken on in_tvalid & in_tready and gives exactly one
// result on the out_ channel; the block holds one request at a time.
// Receive and count walk every live entry with one ram read per cycle;
// a dispatch reads only the head entry. The result register loads in
// the finish state once the walk is over, and the block then returns to
// idle, ready for the next request. With the fifo empty, or for the
// unused mode, the request skips the walk and goes straight to the
// finish state, where the result register loads the same way.
// The result sits in an output register, so a new request is
// taken while it waits; that request stalls in its last cycle until
// out_tready frees the register.
// There is no clearing pass after reset. cfg_wen writes buffer_limit
// (reset 64, used as 1..64) and is meant for idle periods only.
module dedup_packet_fifo_with_window_count_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [dpfifo_pkg::LIMIT_W-1:0]      cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // source, destination, timestamp, window_start, window_end
  input  logic [dpfifo_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_source, out_destination, out_timestamp, window_count, zero pad
  output logic [dpfifo_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // accepted, has_packet
  output logic [1:0]                          out_tuser
);

  dpfifo_pkg::req_t                   in_req;
  dpfifo_pkg::res_t                   out_res;
  dpfifo_pkg::mem_req_t               mem_req;
  logic [dpfifo_pkg::ENTRY_W-1:0]     rd_data;

  assign in_req.mode = in_tuser;
  assign in_req.src  = in_tdata[15:0];
  assign in_req.dst  = in_tdata[31:16];
  assign in_req.ts   = in_tdata[63:32];
  assign in_req.wlo  = in_tdata[95:64];
  assign in_req.whi  = in_tdata[127:96];

  dpfifo_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen_i   (cfg_wen),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .in_req_i    (in_req),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (out_res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  dpfifo_ram #(
    .DEPTH (dpfifo_pkg::MAX_DEPTH),
    .WIDTH (dpfifo_pkg::ENTRY_W),
    .AW    (dpfifo_pkg::PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  assign out_tdata = {1'b0, out_res.window_count, out_res.ts, out_res.dst, out_res.src};
  assign out_tuser = {out_res.has_packet, out_res.accepted};

endmodule

### verif/dedup_packet_fifo_with_window_count_core_test.sv
// self-checking bench for the packet fifo: directed table, then random requests vs. a predictor
`timescale 1ns / 1ps
module dedup_packet_fifo_with_window_count_core_test;
  import dpfifo_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 2 * MAX_DEPTH + 16;
  localparam int PHASE_ITEMS   = 317;

  typedef struct {
    bit                 is_cfg;
    logic [LIMIT_W-1:0] limit;
    req_t               r;
    bit                 typed;
    res_t               exp;
  } step_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wen;
  logic [LIMIT_W-1:0]     cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  // shadow of the fifo
  entry_t             held [MAX_DEPTH];
  int unsigned        head_idx, tail_idx, live, peak_live;
  logic [LIMIT_W-1:0] limit_shadow;
  logic [31:0]        ts_base;

  res_t        expected_results [$];
  step_row_t   directed_steps [$];
  int unsigned tx_idle_pct, rx_stall_pct;
  int unsigned cycles, mismatches, results_checked, sent;
  int unsigned mode_seen [4];
  int unsigned dup_rejects, evictions, empty_dispatches;

  dedup_packet_fifo_with_window_count_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1 >= MAX_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic res_t predict_result(req_t r);
    res_t        o;
    entry_t      key;
    entry_t      e;
    bit          dup;
    int unsigned p, cap, n;
    o = '0;
    key.src = r.src;
    key.dst = r.dst;
    key.ts  = r.ts;
    mode_seen[r.mode]++;
    case (r.mode)
      MODE_RECV: begin
        dup = 1'b0;
        p = head_idx;
        for (int i = 0; i < live; i++) begin
          if (held[p] == key) dup = 1'b1;
          p = wrap_next(p);
        end
        if (dup) begin
          dup_rejects++;
        end else begin
          cap = (limit_shadow == 0) ? 1 : (limit_shadow > MAX_DEPTH) ? MAX_DEPTH : limit_shadow;
          if (live >= cap && live > 0) begin
            head_idx = wrap_next(head_idx);
            live--;
            evictions++;
          end
          held[tail_idx] = key;
          tail_idx = wrap_next(tail_idx);
          live++;
          if (live > peak_live) peak_live = live;
          o.accepted = 1'b1;
        end
      end
      MODE_DISP: begin
        if (live > 0) begin
          e = held[head_idx];
          head_idx = wrap_next(head_idx);
          live--;
          o.has_packet = 1'b1;
          o.src = e.src;
          o.dst = e.dst;
          o.ts  = e.ts;
        end else begin
          empty_dispatches++;
        end
      end
      MODE_COUNT: begin
        n = 0;
        p = head_idx;
        for (int i = 0; i < live; i++) begin
          if (held[p].dst == r.dst && held[p].ts >= r.wlo && held[p].ts <= r.whi) n++;
          p = wrap_next(p);
        end
        o.window_count = (n > CNT_MAX) ? CNT_MAX : CNT_W'(n);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic res_t mk_res(bit acc, bit hp, logic [15:0] s, d, logic [31:0] t,
                                  logic [CNT_W-1:0] c);
    res_t o;
    o = {acc, hp, s, d, t, c};
    return o;
  endfunction

  function automatic step_row_t req_row(logic [1:0] m, logic [15:0] s, d,
                                        logic [31:0] t, lo, hi);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.limit  = '0;
    row.r      = {m, s, d, t, lo, hi};
    row.typed  = 1'b0;
    row.exp    = '0;
    return row;
  endfunction

  function automatic step_row_t chk_row(logic [1:0] m, logic [15:0] s, d,
                                        logic [31:0] t, lo, hi, res_t e);
    step_row_t row;
    row = req_row(m, s, d, t, lo, hi);
    row.typed = 1'b1;
    row.exp   = e;
    return row;
  endfunction

  function automatic step_row_t cfg_row(logic [LIMIT_W-1:0] v);
    step_row_t row;
    row = req_row(MODE_NOP, '0, '0, '0, '0, '0);
    row.is_cfg = 1'b1;
    row.limit  = v;
    return row;
  endfunction

  // mostly well-formed traffic: small address pools, near timestamps, replays of live entries
  function automatic req_t random_request();
    req_t        r;
    entry_t      pick_e;
    int unsigned pick, sel;
    r.src = 16'($urandom);
    r.dst = 16'($urandom);
    r.ts  = $urandom;
    r.wlo = $urandom;
    r.whi = $urandom;
    pick_e = '0;
    if (live > 0) pick_e = held[(head_idx + $urandom_range(live - 1)) % MAX_DEPTH];
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 50) begin
      r.mode = MODE_RECV;
      ts_base = ts_base + $urandom_range(2);
      if (sel < 20 && live > 0) begin
        r.src = pick_e.src;
        r.dst = pick_e.dst;
        r.ts  = pick_e.ts;
      end else if (sel < 85) begin
        r.src = 16'($urandom_range(3));
        r.dst = 16'($urandom_range(3));
        r.ts  = ts_base + $urandom_range(7);
      end
    end else if (pick < 74) begin
      r.mode = MODE_DISP;
    end else if (pick < 97) begin
      r.mode = MODE_COUNT;
      if (sel < 40 && live > 0) begin
        r.dst = pick_e.dst;
        r.wlo = pick_e.ts - $urandom_range(15);
        r.whi = pick_e.ts + $urandom_range(15);
      end else if (sel < 55) begin
        r.dst = 16'($urandom_range(3));
        r.wlo = '0;
        r.whi = '1;
      end else if (sel < 65) begin
        r.dst = 16'($urandom_range(3));
        r.wlo = ts_base + 5;
        r.whi = ts_base;
      end else if (sel < 85) begin
        r.dst = 16'($urandom_range(3));
        r.wlo = ts_base - $urandom_range(20);
        r.whi = ts_base + $urandom_range(20);
      end
    end else begin
      r.mode = MODE_NOP;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, want);
    mismatches++;
    if (mismatches <= 40)
      $display("tb: mismatch on %s at result %0d: got %0h, want %0h",
               what, results_checked, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got, want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unrequested result", out_tdata[63:0], '0);
      return;
    end
    want = expected_results[0];
    expected_results.delete(0);
    check_field("accepted", out_tuser[0], want.accepted);
    check_field("has_packet", out_tuser[1], want.has_packet);
    check_field("out_source", out_tdata[15:0], want.src);
    check_field("out_destination", out_tdata[31:16], want.dst);
    check_field("out_timestamp", out_tdata[63:32], want.ts);
    check_field("window_count", out_tdata[70:64], want.window_count);
    results_checked++;
  endtask

  // result side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) check_result();
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input req_t r, input res_t typed_exp, input bit use_typed);
    res_t e;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.mode;
    in_tdata  <= {r.whi, r.wlo, r.ts, r.dst, r.src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e = predict_result(r);
    expected_results = {expected_results, (use_typed ? typed_exp : e)};
    sent++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    limit_shadow = v;
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit [6];
    cycles = 0;
    mismatches = 0;
    results_checked = 0;
    sent = 0;
    dup_rejects = 0;
    evictions = 0;
    empty_dispatches = 0;
    mode_seen = '{default: 0};
    head_idx = 0;
    tail_idx = 0;
    live = 0;
    peak_live = 0;
    limit_shadow = LIMIT_RESET;
    ts_base = $urandom;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst_n      <= 1'b0;
    cfg_wen    <= 1'b0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= MODE_RECV;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_steps = '{
      chk_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, mk_res(0, 0, 0, 0, 0, 0)),
      chk_row(MODE_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, '1, mk_res(0, 0, 0, 0, 0, 0)),
      chk_row(MODE_NOP, '1, '1, '1, '1, '1, mk_res(0, 0, 0, 0, 0, 0)),
      chk_row(MODE_RECV, '1, '1, '1, '1, '1, mk_res(1, 0, 0, 0, 0, 0)),
      chk_row(MODE_RECV, '1, '1, '1, '1, '1, mk_res(0, 0, 0, 0, 0, 0)),
      chk_row(MODE_RECV, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, mk_res(1, 0, 0, 0, 0, 0)),
      req_row(MODE_RECV, 16'h0, 16'h0, 32'h1, 32'h0, 32'h0),
      req_row(MODE_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, '1),
      req_row(MODE_COUNT, 16'h0, '1, 32'h0, '1, '1),
      chk_row(MODE_COUNT, 16'h0, 16'h0, 32'h0, 32'h1, 32'h0, mk_res(0, 0, 0, 0, 0, 0)),
      chk_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, mk_res(0, 1, '1, '1, '1, 0)),
      cfg_row(7'd2),
      req_row(MODE_RECV, 16'h5, 16'h6, 32'h7, 32'h0, 32'h0),
      req_row(MODE_RECV, 16'h0, 16'h0, 32'h1, 32'h0, 32'h0),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
      cfg_row(7'd0),
      req_row(MODE_RECV, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0),
      req_row(MODE_RECV, 16'h1, 16'h2, 32'h4, 32'h0, 32'h0),
      req_row(MODE_COUNT, 16'h0, 16'h2, 32'h0, 32'h3, 32'h4),
      cfg_row(7'd127),
      req_row(MODE_RECV, 16'h9, 16'h9, 32'h9, 32'h0, 32'h0),
      req_row(MODE_COUNT, 16'h0, 16'h2, 32'h0, 32'h0, '1),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0),
      req_row(MODE_DISP, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0)
    };
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) write_limit(directed_steps[i].limit);
      else send_request(directed_steps[i].r, directed_steps[i].exp, directed_steps[i].typed);
    end

    phase_limit = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd1, 7'($urandom_range(2, 63))};
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(phase_limit[ph]);
      tx_idle_pct  = (ph < 2) ? 8 : (ph < 4) ? 85 : 0;
      rx_stall_pct = (ph < 2) ? 85 : (ph < 4) ? 8 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        send_request(random_request(), '0, 1'b0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d requests (receive %0d, dispatch %0d, count %0d, unused mode %0d), %0d checked",
             sent, mode_seen[MODE_RECV], mode_seen[MODE_DISP], mode_seen[MODE_COUNT],
             mode_seen[MODE_NOP], results_checked);
    $display("tb: %0d duplicates rejected, %0d evictions, %0d empty dispatches, peak fill %0d",
             dup_rejects, evictions, empty_dispatches, peak_live);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
